FILE: sv/fdss_pkg.sv
// ----------------------------------------------------------------------------
// fdss_pkg
// Shared types, constants and decode tables for the four-digit
// seven-segment scan unit.
// ----------------------------------------------------------------------------
package fdss_pkg;

    // All segments dark (active low)
    localparam logic [6:0] SEG_BLANK = 7'h7F;

    // Config register indexes
    localparam int REG_POINT_OFF_MASK = 0;

    // One result toward the pins
    typedef struct packed {
        logic       strobe;
        logic [3:0] digit_select;
        logic [6:0] segments;
        logic       point;
        logic       blanking;
        logic       last;
    } t_result;

    // 10^n, elaboration only
    function automatic int f_pow10_int(input int n);
        int p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // 10^n as a small constant table, n up to 7
    function automatic logic [26:0] f_pow10(input logic [2:0] n);
        logic [26:0] p;
        unique case (n)
            3'd0: p = 27'd1;
            3'd1: p = 27'd10;
            3'd2: p = 27'd100;
            3'd3: p = 27'd1000;
            3'd4: p = 27'd10000;
            3'd5: p = 27'd100000;
            3'd6: p = 27'd1000000;
            3'd7: p = 27'd10000000;
            default: p = 27'd1;
        endcase
        return p;
    endfunction

    // Common-anode a-g pattern, bit 0 is a, 0 lights
    function automatic logic [6:0] f_seg(input logic [3:0] digit);
        logic [6:0] s;
        unique case (digit)
            4'd0: s = 7'h40;
            4'd1: s = 7'h79;
            4'd2: s = 7'h24;
            4'd3: s = 7'h30;
            4'd4: s = 7'h19;
            4'd5: s = 7'h12;
            4'd6: s = 7'h02;
            4'd7: s = 7'h78;
            4'd8: s = 7'h00;
            default: s = 7'h10;  // nine, and clipped codes above nine
        endcase
        return s;
    endfunction

endpackage

FILE: sv/fdss_front.sv
// ----------------------------------------------------------------------------
// fdss_front
// Takes a value, saturates it and peels off one decimal digit per cycle,
// most significant first, then hands the digit word to the queue.
// ----------------------------------------------------------------------------
module fdss_front
    import fdss_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [13:0]                i_value,
    output logic                       o_busy,
    output logic                       o_push,
    output logic [4*DIGIT_COUNT-1:0]   o_digits,
    input  logic                       i_push_ready
);

    localparam int PW    = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int LIMIT = f_pow10_int(DIGIT_COUNT) - 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [PW-1:0]              r_pos;
    logic [13:0]                r_val;
    logic [4*DIGIT_COUNT-1:0]   r_digits;

    logic                       w_accept;
    logic [13:0]                w_sat;
    logic [2:0]                 w_exp;
    logic [26:0]                w_pow;
    logic [26:0]                w_mult;
    logic [26:0]                w_sub;
    logic [3:0]                 w_digit;
    logic [13:0]                w_rem;

    assign o_busy   = (r_state != ST_IDLE) && !((r_state == ST_PUSH) && i_push_ready);
    assign w_accept = i_start && !o_busy;
    assign o_push   = (r_state == ST_PUSH);
    assign o_digits = r_digits;

    assign w_sat = ({18'd0, i_value} > 32'(LIMIT)) ? 14'(LIMIT) : i_value;

    // digit = largest k with k * 10^exp <= value
    always_comb begin
        w_exp   = 3'(DIGIT_COUNT - 1) - 3'(r_pos);
        w_pow   = f_pow10(w_exp);
        w_digit = 4'd0;
        w_sub   = 27'd0;
        w_mult  = 27'd0;
        for (int k = 1; k <= 9; k++) begin
            w_mult = w_pow * 27'(k);
            if ({13'd0, r_val} >= w_mult) begin
                w_digit = 4'(k);
                w_sub   = w_mult;
            end
        end
        w_rem = r_val - w_sub[13:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_CONV;
            ST_CONV: if (r_pos == PW'(DIGIT_COUNT - 1)) n_state = ST_PUSH;
            ST_PUSH: begin
                if (i_push_ready) n_state = w_accept ? ST_CONV : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val <= w_sat;
            r_pos <= '0;
        end else if (r_state == ST_CONV) begin
            r_digits[r_pos*4 +: 4] <= w_digit;
            r_val                  <= w_rem;
            if (r_pos != PW'(DIGIT_COUNT - 1)) r_pos <= r_pos + PW'(1);
        end
    end

endmodule

FILE: sv/fdss_queue.sv
// ----------------------------------------------------------------------------
// fdss_queue
// Two-entry queue of digit words between front and back.
// ----------------------------------------------------------------------------
module fdss_queue
    import fdss_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: sv/fdss_back.sv
// ----------------------------------------------------------------------------
// fdss_back
// Scans one digit word: per position a digit phase then a blanking phase,
// one registered result per cycle while a word is being scanned.
// ----------------------------------------------------------------------------
module fdss_back
    import fdss_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [4*DIGIT_COUNT-1:0]   i_digits,
    output logic                       o_pop,
    input  logic [3:0]                 i_point_off_mask,
    output t_result                    o_result
);

    localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    logic                       r_busy;
    logic                       r_half;
    logic [PW-1:0]              r_pos;
    logic [4*DIGIT_COUNT-1:0]   r_digits;
    t_result                    r_result;

    logic                       w_last_pos;
    logic                       w_done;
    logic                       w_in_range;
    logic [3:0]                 w_sel;
    logic [3:0]                 w_mask_sh;

    assign w_last_pos = (r_pos == PW'(DIGIT_COUNT - 1));
    assign w_done     = r_busy && r_half && w_last_pos;
    assign o_pop      = i_valid && (!r_busy || w_done);
    assign o_result   = r_result;

    assign w_in_range = (int'(r_pos) < 4);
    assign w_sel      = w_in_range ? 4'(4'b0001 << r_pos) : 4'd0;
    assign w_mask_sh  = i_point_off_mask >> r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_digits <= i_digits;
            r_pos    <= '0;
            r_half   <= 1'b0;
        end else if (r_busy) begin
            r_half <= ~r_half;
            if (r_half && !w_last_pos) r_pos <= r_pos + PW'(1);
        end
        if (!i_rst_n) begin
            r_result.strobe <= 1'b0;
        end else begin
            r_result.strobe <= r_busy;
        end
        r_result.digit_select <= w_sel;
        r_result.segments     <= r_half ? SEG_BLANK : f_seg(r_digits[r_pos*4 +: 4]);
        r_result.point        <= r_half ? 1'b1 : (w_in_range ? w_mask_sh[0] : 1'b1);
        r_result.blanking     <= r_half;
        r_result.last         <= r_half && w_last_pos;
    end

endmodule

FILE: sv/four_digit_seven_segment_scan_unit.sv
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scan_unit
// Multiplexed seven-segment scan driver: value in, digit and blanking
// phases out, one per cycle while a value is scanned.
// ----------------------------------------------------------------------------
// A value is taken on start while busy is low. It is clamped to the largest
// number the digits can show (9999 with four digits) and each position,
// leftmost first, produces two results on o_strobe: the digit phase
// (one-hot select, active-low a-g, active-low point from point_off_mask)
// and a blanking phase with the same select and everything dark. The
// eighth result (2*DIGIT_COUNT in general) carries o_last. A value's
// results come out on consecutive cycles with no gaps and the receiver
// cannot stall them, the scan stage emitting one result per cycle while
// it scans a value. The digit splitter in front feeds a two-entry queue,
// so it works ahead while the scan stage is still busy.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scan_unit
    import fdss_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic [13:0] i_value,
    // result side
    output logic        o_strobe,
    output logic [3:0]  o_digit_select,
    output logic [6:0]  o_segments,
    output logic        o_point,
    output logic        o_blanking,
    output logic        o_last,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = 4 * DIGIT_COUNT;

    logic [3:0]     r_point_off_mask;
    logic           w_cfg_sel;
    logic           w_push, w_push_ready;
    logic [DW-1:0]  w_front_digits;
    logic           w_q_valid, w_pop;
    logic [DW-1:0]  w_q_digits;
    t_result        w_result;

    // Config: one register, byte address 4*index, paddr[2] is the index
    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[2] == 1'(REG_POINT_OFF_MASK));
    assign prdata    = w_cfg_sel ? {28'd0, r_point_off_mask} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_off_mask <= 4'hF;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_point_off_mask <= pwdata[3:0];
        end
    end

    // Front: clamp and split into digits
    fdss_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_value      (i_value),
        .o_busy       (busy),
        .o_push       (w_push),
        .o_digits     (w_front_digits),
        .i_push_ready (w_push_ready)
    );

    // Decoupling queue
    fdss_queue #(
        .WIDTH (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_digits),
        .o_ready (w_push_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_digits)
    );

    // Back: scan positions, one transfer per cycle while scanning
    fdss_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_q_valid),
        .i_digits         (w_q_digits),
        .o_pop            (w_pop),
        .i_point_off_mask (r_point_off_mask),
        .o_result         (w_result)
    );

    assign o_strobe       = w_result.strobe;
    assign o_digit_select = w_result.digit_select;
    assign o_segments     = w_result.segments;
    assign o_point        = w_result.point;
    assign o_blanking     = w_result.blanking;
    assign o_last         = w_result.last;

    // last only ever marks a blanking transfer
    a_last_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> o_blanking)
        else $error("last on a digit phase");

    // a blanking phase keeps the select of the digit phase just before it
    a_blank_follows_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_blanking) |->
            ($past(o_strobe) && !$past(o_blanking)
             && o_digit_select == $past(o_digit_select)))
        else $error("blanking phase out of order");

    // blanking phase is fully dark
    a_blank_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_blanking) |-> (o_segments == SEG_BLANK && o_point))
        else $error("blanking phase lights a segment");

    // at most one position selected
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot0(o_digit_select))
        else $error("digit select not one-hot");

endmodule
